// ----- rtl/mpde_pkg.sv -----
`timescale 1ns / 1ps
package mpde_pkg;

  // Storage depth for the points of one frame.
  localparam int MAX_MARKERS = 16;
  localparam int PS_AW       = $clog2(MAX_MARKERS);
  localparam int VC_W        = $clog2(MAX_MARKERS + 1);

  // Fixed field widths.
  localparam int SLOT_W  = 4;
  localparam int COORD_W = 32;
  localparam int DIST_W  = 32;
  localparam int PAIR_W  = 7;
  localparam int VIS_W   = 5;
  localparam int STAT_W  = 2;
  localparam int SUM_W   = 40;
  localparam int MC_W    = 5;
  localparam int TAB_AW  = 2 * SLOT_W;

  // Stream word widths.
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 48;

  // Configuration port.
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 5;
  localparam logic [CFG_AW-1:0] REG_MARKER_COUNT = 1'd0;
  localparam logic [CFG_AW-1:0] REG_TABLE_VALID  = 1'd1;

  // Input item modes.
  localparam logic MODE_TABLE = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_TABLE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_PAIRS = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // One stored marker: slot and coordinates.
  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

endpackage

// ----- rtl/mpde_sqrt.sv -----
`timescale 1ns / 1ps
module mpde_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import mpde_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] rad_r, rad_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  // One result bit per cycle, two radicand bits brought down each step.
  always_comb begin
    rem_sh   = {rem_r[32:0], rad_r[63:62]};
    trial    = {1'b0, root_r, 2'b01};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("root done without a running pass");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("root started while busy");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("root done while still busy");

endmodule

// ----- rtl/mpde_div.sv -----
`timescale 1ns / 1ps
module mpde_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mpde_pkg::SUM_W-1:0]  dividend,
  input  logic [mpde_pkg::PAIR_W-1:0] divisor,
  output logic                       done,
  output logic [mpde_pkg::SUM_W-1:0]  quotient
);
  import mpde_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  dq_r, dq_nxt;
  logic [PAIR_W:0]   rem_r, rem_nxt;
  logic [PAIR_W-1:0] dvs_r, dvs_nxt;
  logic [PAIR_W:0]   rem_sh;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh   = {rem_r[PAIR_W-1:0], dq_r[SUM_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        dq_nxt  = {dq_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        dq_nxt  = {dq_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(start) |-> rem_r < {1'b0, dvs_r}) else $error("remainder too large");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divide started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divide done without a running pass");

endmodule

// ----- rtl/marker_pair_distance_error.sv -----
`timescale 1ns / 1ps
// Marker pair distance error. Table words (tuser = 0) write one reference
// distance. Point words (tuser = 1) store a visible marker and, when the
// table is valid, compare it with every marker stored earlier in the frame;
// each pair reads the point store and the distance table, squares the three
// coordinate differences on one shared 32x32 multiplier and, unless the sum
// overflows, runs a square root of 32 steps. The point word flagged with
// tlast closes the frame; its result follows, after a divide when the table
// is valid and pairs exist. The output register lets a result wait while
// the next word is taken.
module marker_pair_distance_error (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mpde_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [mpde_pkg::CFG_DW-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // slot_a, slot_b, ref_distance, pos_x, pos_y, pos_z
  input  logic [mpde_pkg::IN_DATA_W-1:0]   in_tdata,
  // mode
  input  logic                             in_tuser,
  // frame_end
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // mean_error, pair_total, visible_total, zero fill
  output logic [mpde_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status
  output logic [mpde_pkg::STAT_W-1:0]      out_tuser
);
  import mpde_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NEXT, S_DIF, S_MUL0, S_MUL1, S_MUL2, S_ACC,
    S_ROOT, S_WAIT, S_ERR, S_CLOSE, S_DIV, S_EMIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [MC_W-1:0] marker_count_r;
  logic            table_valid_r;

  // Memories.
  logic [DIST_W-1:0] dist_mem [2**TAB_AW];
  point_t            pt_mem [MAX_MARKERS];
  logic [DIST_W-1:0] dist_q_r;
  point_t            pt_q_r;

  // Frame state.
  logic [VC_W-1:0]   vc_r;
  logic [PAIR_W-1:0] pc_r;
  logic [SUM_W-1:0]  esum_r;

  // Current point and pair loop.
  point_t            cur_r;
  logic              fend_r;
  logic [VC_W-1:0]   n_r;
  logic [PS_AW-1:0]  idx_r;
  logic [COORD_W:0]  mx_r, my_r, mz_r;
  logic              ovf_r;
  logic [63:0]       prod_r;
  logic [65:0]       sum_r;
  logic [DIST_W-1:0] d_r;
  logic [STAT_W-1:0] stat_r;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [STAT_W-1:0]     out_user_r;

  // Input word fields.
  logic [SLOT_W-1:0]  in_slot_a, in_slot_b;
  logic [DIST_W-1:0]  in_ref;
  point_t             in_pt;
  logic               in_acc, in_vis;

  assign in_slot_a = in_tdata[3:0];
  assign in_slot_b = in_tdata[7:4];
  assign in_ref    = in_tdata[39:8];
  assign in_pt     = '{slot: in_slot_a, z: in_tdata[135:104], y: in_tdata[103:72],
                       x: in_tdata[71:40]};
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_vis    = (in_pt.x != '0 || in_pt.y != '0 || in_pt.z != '0) &&
                     ({1'b0, in_slot_a} < marker_count_r) &&
                     (vc_r < VC_W'(MAX_MARKERS));

  // Coordinate differences and their magnitudes.
  logic signed [COORD_W:0] dx, dy, dz;
  assign dx = {pt_q_r.x[COORD_W-1], pt_q_r.x} - {cur_r.x[COORD_W-1], cur_r.x};
  assign dy = {pt_q_r.y[COORD_W-1], pt_q_r.y} - {cur_r.y[COORD_W-1], cur_r.y};
  assign dz = {pt_q_r.z[COORD_W-1], pt_q_r.z} - {cur_r.z[COORD_W-1], cur_r.z};

  // Shared multiplier operand.
  logic [COORD_W-1:0] mul_op;
  always_comb begin
    unique case (state_r)
      S_MUL0:  mul_op = mx_r[COORD_W-1:0];
      S_MUL1:  mul_op = my_r[COORD_W-1:0];
      default: mul_op = mz_r[COORD_W-1:0];
    endcase
  end

  // Square root and divide units.
  logic              sq_start, sq_done;
  logic [31:0]       sq_root;
  logic              dv_start, dv_done;
  logic [SUM_W-1:0]  dv_quot;

  assign sq_start = (state_r == S_ROOT) && !(ovf_r || sum_r[65:64] != 2'b00);
  assign dv_start = (state_r == S_CLOSE) && fend_r && table_valid_r && (pc_r != '0);

  mpde_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_r[63:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  mpde_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (esum_r),
    .divisor  (pc_r),
    .done     (dv_done),
    .quotient (dv_quot)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_count_r <= MC_W'(4);
      table_valid_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MARKER_COUNT: marker_count_r <= cfg_wdata[MC_W-1:0];
        REG_TABLE_VALID:  table_valid_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Distance table: written by table words, read with the stored slot as row.
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == MODE_TABLE) begin
      dist_mem[{in_slot_a, in_slot_b}] <= in_ref;
    end
    dist_q_r <= dist_mem[{pt_q_r.slot, cur_r.slot}];
  end

  // Point store: written at the next free entry, read by the pair loop.
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == MODE_POINT && in_vis) begin
      pt_mem[vc_r[PS_AW-1:0]] <= in_pt;
    end
    pt_q_r <= pt_mem[idx_r];
  end

  // Sequencer and registered outputs.
  logic [DIST_W-1:0] err;
  assign err = (d_r >= dist_q_r) ? d_r - dist_q_r : dist_q_r - d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= '0;
      pc_r        <= '0;
      esum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser == MODE_POINT) begin
            cur_r  <= in_pt;
            fend_r <= in_tlast;
            n_r    <= vc_r;
            idx_r  <= '0;
            if (in_vis) begin
              vc_r <= vc_r + VC_W'(1);
              pc_r <= pc_r + PAIR_W'(vc_r);
            end
            if (in_vis && table_valid_r && vc_r != '0) begin
              state_r <= S_NEXT;
            end else begin
              state_r <= S_CLOSE;
            end
          end
        end
        S_NEXT: state_r <= S_DIF;
        S_DIF: begin
          mx_r    <= dx[COORD_W] ? -dx : dx;
          my_r    <= dy[COORD_W] ? -dy : dy;
          mz_r    <= dz[COORD_W] ? -dz : dz;
          state_r <= S_MUL0;
        end
        S_MUL0: begin
          ovf_r   <= mx_r[COORD_W] | my_r[COORD_W] | mz_r[COORD_W];
          prod_r  <= mul_op * mul_op;
          sum_r   <= '0;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          prod_r  <= mul_op * mul_op;
          sum_r   <= sum_r + {2'b00, prod_r};
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= mul_op * mul_op;
          sum_r   <= sum_r + {2'b00, prod_r};
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_r + {2'b00, prod_r};
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_start) begin
            state_r <= S_WAIT;
          end else begin
            d_r     <= DIST_MAX;
            state_r <= S_ERR;
          end
        end
        S_WAIT: begin
          if (sq_done) begin
            d_r     <= sq_root;
            state_r <= S_ERR;
          end
        end
        S_ERR: begin
          esum_r <= esum_r + SUM_W'(err);
          idx_r  <= idx_r + PS_AW'(1);
          if (VC_W'(idx_r) + VC_W'(1) == n_r) begin
            state_r <= S_CLOSE;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_CLOSE: begin
          priority if (!fend_r) begin
            state_r <= S_IDLE;
          end else if (!table_valid_r) begin
            stat_r  <= ST_NO_TABLE;
            state_r <= S_EMIT;
          end else if (pc_r == '0) begin
            stat_r  <= ST_NO_PAIRS;
            state_r <= S_EMIT;
          end else begin
            stat_r  <= ST_OK;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= stat_r;
            out_data_r  <= {4'b0000, VIS_W'(vc_r), pc_r,
                            (stat_r == ST_OK) ? dv_quot[DIST_W-1:0] : DIST_W'(0)};
            vc_r        <= '0;
            pc_r        <= '0;
            esum_r      <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r <= VC_W'(MAX_MARKERS)) else $error("point store overfilled");
  a_loop_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NEXT |-> VC_W'(idx_r) < n_r) else $error("pair index past stored points");
  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == S_WAIT) else $error("root result outside wait");
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && (!out_valid_r || out_tready) |=> vc_r == '0 && out_valid_r)
    else $error("frame not closed on result");

endmodule

// ----- tb/sv/marker_pair_distance_error_tb.sv -----
`timescale 1ns / 1ps
module marker_pair_distance_error_tb;
  import mpde_pkg::*;

  // One expected frame result.
  typedef struct {
    logic [31:0] mean;
    logic [6:0]  pairs;
    logic [4:0]  seen;
    logic [1:0]  status;
  } frame_result_t;

  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 700;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr = '0;
  logic [CFG_DW-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  marker_pair_distance_error uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block state.
  logic [31:0]        ref_table [256];
  logic signed [31:0] frame_x [MAX_MARKERS];
  logic signed [31:0] frame_y [MAX_MARKERS];
  logic signed [31:0] frame_z [MAX_MARKERS];
  logic [3:0]         frame_slot [MAX_MARKERS];
  int unsigned        frame_seen;
  logic [39:0]        frame_err_sum;
  int unsigned        frame_pairs;
  logic [4:0]         slot_limit;
  logic               table_ok;

  frame_result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int status_hits [3] = '{0, 0, 0};
  bit calm = 1'b0;
  int quiet = 0;

  // Squared difference of one coordinate; the magnitude always fits 32 bits.
  function automatic logic [63:0] axis_square(logic signed [31:0] a, logic signed [31:0] b);
    logic [32:0] d;
    logic [31:0] m;
    d = {a[31], a} - {b[31], b};
    m = d[32] ? 32'(-d) : d[31:0];
    return 64'(m) * 64'(m);
  endfunction

  // Truncated Euclidean distance between a stored marker and a new one.
  function automatic logic [31:0] marker_distance(int idx, logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z);
    logic [65:0] acc;
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] bitv;
    acc = 66'(axis_square(frame_x[idx], x)) + 66'(axis_square(frame_y[idx], y))
        + 66'(axis_square(frame_z[idx], z));
    if (acc[65:64] != 2'b00) return DIST_MAX;
    n = acc[63:0];
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  // Update the shadow state for one accepted word and queue any frame result.
  task automatic track_word(logic mode, logic [IN_DATA_W-1:0] data, logic last);
    logic [3:0] sa;
    logic [3:0] sb;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0] d;
    logic [31:0] r;
    frame_result_t res;
    sa = data[3:0];
    sb = data[7:4];
    x = data[71:40];
    y = data[103:72];
    z = data[135:104];
    if (mode == MODE_TABLE) begin
      ref_table[{sa, sb}] = data[39:8];
      return;
    end
    if (!(x == 0 && y == 0 && z == 0) && sa < slot_limit && frame_seen < MAX_MARKERS) begin
      for (int i = 0; i < frame_seen; i++) begin
        if (table_ok) begin
          d = marker_distance(i, x, y, z);
          r = ref_table[{frame_slot[i], sa}];
          frame_err_sum += 40'((d >= r) ? d - r : r - d);
        end
        frame_pairs++;
      end
      frame_x[frame_seen] = x;
      frame_y[frame_seen] = y;
      frame_z[frame_seen] = z;
      frame_slot[frame_seen] = sa;
      frame_seen++;
    end
    if (!last) return;
    res.mean = '0;
    if (!table_ok) begin
      res.status = ST_NO_TABLE;
    end else if (frame_pairs == 0) begin
      res.status = ST_NO_PAIRS;
    end else begin
      res.status = ST_OK;
      res.mean = 32'(frame_err_sum / frame_pairs);
    end
    res.pairs = 7'(frame_pairs);
    res.seen = 5'(frame_seen);
    pending_results = {pending_results, res};
    frame_seen = 0;
    frame_err_sum = '0;
    frame_pairs = 0;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
  endtask

  // Sends one word, with an occasional burst of idle cycles first while calm is clear.
  task automatic send_word(logic mode, logic [IN_DATA_W-1:0] data, logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= data;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    track_word(mode, data, last);
    words_sent++;
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_word(logic [3:0] sa, logic [3:0] sb,
                                                     logic [31:0] rd, logic [31:0] x,
                                                     logic [31:0] y, logic [31:0] z);
    return {z, y, x, rd, sb, sa};
  endfunction

  task automatic send_point(logic [3:0] sa, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z, logic last);
    send_word(MODE_POINT, pack_word(sa, 4'($urandom), $urandom, x, y, z), last);
  endtask

  task automatic send_entry(logic [3:0] row, logic [3:0] col, logic [31:0] rd);
    send_word(MODE_TABLE, pack_word(row, col, rd, $urandom, $urandom, $urandom),
              1'($urandom));
  endtask

  // Waits for every expected result plus the block's worst point latency.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_MARKER_COUNT) slot_limit = value;
    else table_ok = value[0];
  endtask

  // Table invalid: pairs counted, no error, invisible points, frame end on a skipped point.
  task automatic test_table_invalid();
    send_entry(4'd2, 4'd9, 32'h1234_5678);
    send_point(4'd0, 32'h0001_0000, 32'h0, 32'h0, 1'b0);
    send_point(4'd1, 32'h0, 32'h0002_0000, 32'hFFFF_0000, 1'b0);
    send_point(4'd5, 32'h0003_0000, 32'h0, 32'h0, 1'b0);
    send_point(4'd2, 32'h0, 32'h0, 32'h0, 1'b0);
    send_point(4'd3, 32'h0, 32'h0, 32'h0, 1'b1);
    send_point(4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b1);
  endtask

  // Fills the whole reference table so that no unwritten entry is ever read.
  task automatic test_table_fill();
    for (int i = 0; i < 256; i++) begin
      case (i % 16)
        0:       send_entry(4'(i >> 4), 4'(i), 32'h0);
        1:       send_entry(4'(i >> 4), 4'(i), 32'hFFFF_FFFF);
        default: send_entry(4'(i >> 4), 4'(i), $urandom);
      endcase
    end
  endtask

  // Valid table: saturated distance, repeated slot, lone marker, empty frame, one-slot limit.
  task automatic test_special_frames();
    settle();
    write_reg(REG_TABLE_VALID, 5'd1);
    write_reg(REG_MARKER_COUNT, 5'd16);
    send_point(4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(4'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_point(4'd7, 32'h0000_8000, 32'h0, 32'h0, 1'b0);
    send_point(4'd7, 32'h0, 32'h0000_C000, 32'h0, 1'b1);
    send_point(4'd3, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    send_point(4'd4, 32'h0, 32'h0, 32'h0, 1'b1);
    settle();
    write_reg(REG_MARKER_COUNT, 5'd1);
    send_point(4'd0, 32'h0010_0000, 32'h0, 32'h0, 1'b0);
    send_point(4'd1, 32'h0020_0000, 32'h0, 32'h0, 1'b0);
    send_point(4'd0, 32'hFFF0_0000, 32'h0, 32'h0, 1'b1);
  endtask

  // Seventeen nonzero markers in valid slots: the last one finds the store full.
  task automatic test_store_full();
    settle();
    write_reg(REG_MARKER_COUNT, 5'd16);
    for (int i = 0; i <= MAX_MARKERS; i++)
      send_point(4'(i), $urandom, $urandom, $urandom, 1'b0);
    send_point(4'd2, 32'h0, 32'h0, 32'h0, 1'b1);
  endtask

  function automatic logic [31:0] coord_value(int kind);
    if (kind == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
  endfunction

  // Random frames under a series of register settings.
  task automatic test_random_frames(int budget);
    int n;
    int kind;
    int phase;
    logic [3:0] sa;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    phase = 0;
    while (budget > 0) begin
      settle();
      case (phase % 4)
        0:       write_reg(REG_MARKER_COUNT, 5'd16);
        1:       write_reg(REG_MARKER_COUNT, 5'd1);
        default: write_reg(REG_MARKER_COUNT, 5'($urandom_range(2, 15)));
      endcase
      write_reg(REG_TABLE_VALID, 5'($urandom_range(0, 4) != 0));
      for (int f = 0; f < 20 && budget > 0; f++) begin
        if (budget < 200) calm = 1'b1;
        n = $urandom_range(1, 9);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(10, 18);
        kind = $urandom_range(0, 1);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            send_entry(4'($urandom), 4'($urandom), $urandom);
            budget--;
          end
          sa = ($urandom_range(0, 6) == 0) ? 4'($urandom)
                                            : 4'($urandom_range(0, slot_limit - 1));
          x = coord_value(kind);
          y = coord_value(kind);
          z = coord_value(kind);
          if ($urandom_range(0, 9) == 0) begin
            x = 0;
            y = 0;
            z = 0;
          end
          send_point(sa, x, y, z, k == n - 1);
          budget--;
        end
      end
      phase++;
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result word", out_tdata[31:0], 32'(0));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.mean) report("mean_error", out_tdata[31:0], want.mean);
        if (out_tdata[38:32] !== want.pairs)
          report("pair_total", 32'(out_tdata[38:32]), 32'(want.pairs));
        if (out_tdata[43:39] !== want.seen)
          report("visible_total", 32'(out_tdata[43:39]), 32'(want.seen));
        if (out_tuser !== want.status) report("status", 32'(out_tuser), 32'(want.status));
        if (want.status <= ST_NO_PAIRS) status_hits[want.status]++;
      end
      results_seen++;
    end
  end

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    int stall;
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall > 0) begin
      stall--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall = $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("marker_pair_distance_error_tb: errors");
      $finish;
    end
  end

  initial begin
    frame_seen = 0;
    frame_err_sum = '0;
    frame_pairs = 0;
    slot_limit = 5'd4;
    table_ok = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_invalid();
    test_table_fill();
    test_special_frames();
    test_store_full();
    test_random_frames(1300);
    settle();
    $display("Sent %0d words; checked %0d frame results.", words_sent, results_seen);
    $display("Status counts: ok %0d, table not valid %0d, no pairs %0d.",
             status_hits[0], status_hits[1], status_hits[2]);
    if (errors == 0) begin
      $display("marker_pair_distance_error_tb: clean");
    end else begin
      $display("marker_pair_distance_error_tb: errors");
    end
    $finish;
  end

endmodule

// ----- marker_pair_distance_error.f -----
rtl/mpde_pkg.sv
rtl/mpde_sqrt.sv
rtl/mpde_div.sv
rtl/marker_pair_distance_error.sv
tb/sv/marker_pair_distance_error_tb.sv
